// File: rtl/njs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// njs_pkg - shared types and constants of the job scheduler
// Field widths, policy and request codes, and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package njs_pkg;

  localparam int SLOTS     = 8;
  localparam int TIME_BITS = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int ID_W      = 8;
  localparam int NEED_W    = 12;
  localparam int OUT_W     = 16;
  localparam int ORDER_W   = 16;
  localparam int POL_W     = 2;
  localparam int PROD_W    = TIME_BITS + NEED_W;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int REG_W     = CFG_AW - 2;

  localparam logic [POL_W-1:0] POL_FCFS = 2'd0;
  localparam logic [POL_W-1:0] POL_SJF  = 2'd1;
  localparam logic [POL_W-1:0] POL_HRRN = 2'd2;

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  localparam logic STAT_DONE   = 1'b0;
  localparam logic STAT_REJECT = 1'b1;

  localparam logic [REG_W-1:0] REG_POLICY = 1'b0;

  typedef struct packed {
    logic              req_type;
    logic [ID_W-1:0]   job_id;
    logic [NEED_W-1:0] need_time;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic [ID_W-1:0]  done_id;
    logic [OUT_W-1:0] end_time;
    logic [OUT_W-1:0] turnaround;
    logic [OUT_W-1:0] wait_time;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic write_slot;
    logic emit_reject;
    logic emit_done;
    logic advance_run;
    logic scan_clear;
    logic scan_mul;
    logic scan_cmp;
    logic pick;
  } njs_cmd_t;

  typedef struct packed {
    logic              need_zero;
    logic              table_full;
    logic              run_valid;
    logic              run_done;
    logic              out_busy;
    logic              scan_last;
    logic [NEED_W-1:0] run_used;
    logic [NEED_W-1:0] run_need;
  } njs_status_t;

endpackage
`default_nettype wire

// File: rtl/njs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// njs_ctrl - scheduler sequencer
// Takes one request at a time, decodes arrival or tick, and steps the
// datapath through completion, the slot scan and the pick.
// ----------------------------------------------------------------------------
module njs_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_req_type,
  output logic                 in_ready,
  input  njs_pkg::njs_status_t st,
  output njs_pkg::njs_cmd_t    cmd
);
  import njs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ARR  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_PICK = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_req_type == REQ_TICK) ? S_CHK : S_ARR;
        end
      end
      S_ARR: begin
        if (st.need_zero) begin
          state_nxt = S_IDLE;
        end else if (!st.table_full) begin
          cmd.write_slot = 1'b1;
          state_nxt      = S_IDLE;
        end else if (!st.out_busy) begin
          cmd.emit_reject = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_CHK: begin
        if (st.run_done) begin
          // hold until the result register frees up
          if (!st.out_busy) begin
            cmd.emit_done  = 1'b1;
            cmd.scan_clear = 1'b1;
            state_nxt      = S_MUL;
          end
        end else if (st.run_valid) begin
          cmd.advance_run = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cmd.scan_clear = 1'b1;
          state_nxt      = S_MUL;
        end
      end
      S_MUL: begin
        cmd.scan_mul = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        cmd.scan_cmp = 1'b1;
        state_nxt    = st.scan_last ? S_PICK : S_MUL;
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/njs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// njs_datapath - ready table, running job, selection unit and result register
// The slot scan visits the slots one at a time: cross-products are
// registered first, then compared against the best candidate so far.
// ----------------------------------------------------------------------------
module njs_datapath (
  input  wire                        clk,
  input  wire                        rst_n,
  input  njs_pkg::in_item_t          in_data,
  input  wire [njs_pkg::POL_W-1:0]   policy,
  input  njs_pkg::njs_cmd_t          cmd,
  output njs_pkg::njs_status_t       st,
  output logic                       out_valid,
  input  wire                        out_ready,
  output njs_pkg::out_item_t         out_data
);
  import njs_pkg::*;

  // captured request
  in_item_t item_r;

  // ready table
  logic [SLOTS-1:0]     slot_valid_r;
  logic [ID_W-1:0]      slot_id_r      [SLOTS];
  logic [TIME_BITS-1:0] slot_arrival_r [SLOTS];
  logic [NEED_W-1:0]    slot_need_r    [SLOTS];
  logic [ORDER_W-1:0]   slot_order_r   [SLOTS];
  logic [ORDER_W-1:0]   order_cnt_r;
  logic [TIME_BITS-1:0] now_r;

  // running job
  logic                 run_valid_r;
  logic [ID_W-1:0]      run_id_r;
  logic [TIME_BITS-1:0] run_arrival_r;
  logic [NEED_W-1:0]    run_need_r;
  logic [NEED_W-1:0]    run_used_r;

  // selection unit
  logic [SLOT_W-1:0]    scan_idx_r;
  logic                 have_best_r;
  logic [SLOT_W-1:0]    best_idx_r;
  logic [ID_W-1:0]      best_id_r;
  logic [TIME_BITS-1:0] best_arrival_r;
  logic [NEED_W-1:0]    best_need_r;
  logic [ORDER_W-1:0]   best_age_r;
  logic [PROD_W-1:0]    lhs_r, rhs_r;

  // result register
  logic      out_valid_r;
  out_item_t out_data_r;

  logic [SLOT_W-1:0]    free_idx;
  logic                 free_found;
  logic [TIME_BITS-1:0] cand_wait, best_wait, turn, wait_t;
  logic [ORDER_W-1:0]   cand_age;
  logic [NEED_W-1:0]    cand_need;
  logic                 better;

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!slot_valid_r[s] && !free_found) begin
        free_idx   = SLOT_W'(s);
        free_found = 1'b1;
      end
    end
  end

  assign cand_need = slot_need_r[scan_idx_r];
  assign cand_wait = now_r - slot_arrival_r[scan_idx_r];
  assign best_wait = now_r - best_arrival_r;
  assign cand_age  = order_cnt_r - slot_order_r[scan_idx_r];
  assign turn      = now_r - run_arrival_r;
  assign wait_t    = turn - TIME_BITS'(run_need_r);

  // ties go to the older entry
  always_comb begin
    case (policy)
      POL_SJF: begin
        better = (cand_need == best_need_r) ? (cand_age > best_age_r)
                                            : (cand_need < best_need_r);
      end
      POL_HRRN: begin
        better = (lhs_r == rhs_r) ? (cand_age > best_age_r) : (lhs_r > rhs_r);
      end
      default: begin
        better = cand_age > best_age_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.write_slot) begin
      slot_id_r[free_idx]      <= item_r.job_id;
      slot_arrival_r[free_idx] <= now_r;
      slot_need_r[free_idx]    <= item_r.need_time;
      slot_order_r[free_idx]   <= order_cnt_r;
    end
    if (cmd.scan_mul) begin
      lhs_r <= PROD_W'(cand_wait) * PROD_W'(best_need_r);
      rhs_r <= PROD_W'(best_wait) * PROD_W'(cand_need);
    end
    if (cmd.scan_cmp && slot_valid_r[scan_idx_r] && (!have_best_r || better)) begin
      best_idx_r     <= scan_idx_r;
      best_id_r      <= slot_id_r[scan_idx_r];
      best_arrival_r <= slot_arrival_r[scan_idx_r];
      best_need_r    <= cand_need;
      best_age_r     <= cand_age;
    end
    if (cmd.pick && have_best_r) begin
      run_id_r      <= best_id_r;
      run_arrival_r <= best_arrival_r;
      run_need_r    <= best_need_r;
    end
    if (cmd.emit_reject) begin
      out_data_r <= '{status: STAT_REJECT, done_id: item_r.job_id,
                      end_time: '0, turnaround: '0, wait_time: '0};
    end else if (cmd.emit_done) begin
      out_data_r <= '{status: STAT_DONE, done_id: run_id_r,
                      end_time: OUT_W'(now_r), turnaround: OUT_W'(turn),
                      wait_time: OUT_W'(wait_t)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      order_cnt_r  <= '0;
      now_r        <= '0;
      run_valid_r  <= 1'b0;
      run_used_r   <= '0;
      scan_idx_r   <= '0;
      have_best_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.write_slot) begin
        slot_valid_r[free_idx] <= 1'b1;
        order_cnt_r            <= order_cnt_r + 1'b1;
      end
      if (cmd.emit_done) begin
        run_valid_r <= 1'b0;
      end
      if (cmd.advance_run) begin
        now_r      <= now_r + 1'b1;
        run_used_r <= run_used_r + 1'b1;
      end
      if (cmd.scan_clear) begin
        scan_idx_r  <= '0;
        have_best_r <= 1'b0;
      end
      if (cmd.scan_cmp) begin
        scan_idx_r <= scan_idx_r + 1'b1;
        if (slot_valid_r[scan_idx_r]) begin
          have_best_r <= 1'b1;
        end
      end
      if (cmd.pick) begin
        now_r <= now_r + 1'b1;
        if (have_best_r) begin
          slot_valid_r[best_idx_r] <= 1'b0;
          run_valid_r              <= 1'b1;
          run_used_r               <= NEED_W'(1);
        end
      end
      if (cmd.emit_reject || cmd.emit_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.need_zero  = (item_r.need_time == '0);
  assign st.table_full = !free_found;
  assign st.run_valid  = run_valid_r;
  assign st.run_done   = run_valid_r && (run_used_r == run_need_r);
  assign st.out_busy   = out_valid_r && !out_ready;
  assign st.scan_last  = (scan_idx_r == SLOT_W'(SLOTS - 1));
  assign st.run_used   = run_used_r;
  assign st.run_need   = run_need_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: rtl/nonpreemptive_job_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nonpreemptive_job_scheduler_core - single-server FCFS / SJF / HRRN scheduler
// Arrival requests fill an eight-slot ready table; tick requests run one time
// step, report a finished job and pick the next one by the policy register.
// Usage: in_valid/in_ready carry one request (arrival or tick) per transfer;
//   out_valid/out_ready carry a completion or a rejected arrival. The APB port
//   holds the policy register at address 0 (0 FCFS, 1 shortest need, 2 highest
//   response ratio); pready is always high.
// Timing: an arrival, or a tick while a job is still running, goes through
//   its decode step and back to idle before the next request. A tick that
//   finds the server idle or completes the running job also runs the
//   selection unit, which shares one cross-multiply and compare over the
//   slots, one slot at a time, and then picks. With the receiver keeping up,
//   a result is registered into the output register by its decode step.
// Back-pressure: a request that must emit a result holds in its decode step
//   until the output register frees; other requests carry on.
// Reset: rst_n low clears the table, the time, the running job and the policy.
// ----------------------------------------------------------------------------
module nonpreemptive_job_scheduler_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  njs_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output njs_pkg::out_item_t           out_data,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [njs_pkg::CFG_AW-1:0]   paddr,
  input  wire  [njs_pkg::CFG_DW-1:0]   pwdata,
  output logic [njs_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);
  import njs_pkg::*;

  logic [POL_W-1:0] policy_r;
  njs_cmd_t         cmd;
  njs_status_t      st;
  logic [REG_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FCFS;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_POLICY)) begin
      policy_r <= pwdata[POL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_POLICY) begin
      prdata = CFG_DW'(policy_r);
    end
  end

  njs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_ready    (in_ready),
    .st          (st),
    .cmd         (cmd)
  );

  njs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .policy    (policy_r),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // a running job never has more service than it needs
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st.run_valid |-> (st.run_used <= st.run_need))
    else $error("running job over-served");

  // a freshly picked job has had exactly one unit
  a_pick_first_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st.run_valid) |-> (st.run_used == 1))
    else $error("picked job did not start with one unit");

  // no result can be produced in the cycle straight after a request transfer
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared too early");
`endif

endmodule
`default_nettype wire
